@@ hw/rtl/aes_cbc_pkg.sv @@
`default_nettype none

package aes_cbc_pkg;

  // Register indexes on the config port
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_KEY_HI  = 3'd1;
  localparam logic [2:0] REG_KEY_LO  = 3'd2;
  localparam logic [2:0] REG_IV_HI   = 3'd3;
  localparam logic [2:0] REG_IV_LO   = 3'd4;

  localparam logic [3:0] LAST_ROUND  = 4'd10;
  localparam logic [7:0] GF_POLY     = 8'h1b;

  // Command from controller to datapath
  typedef struct packed {
    logic       load;   // word accepted this cycle
    logic       kexp;   // forward key expansion step only
    logic       addk;   // initial key addition for decryption
    logic       round;  // one cipher round
    logic       dec;    // decrypt direction
    logic [3:0] rnd;    // current round number
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // Round constant used when deriving the key of round r
  function automatic logic [7:0] rcon(logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sub_rot(logic [31:0] w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // Next round key from the current one
  function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rc, 24'h0};
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // Previous round key; rc is the constant of the current round
  function automatic logic [127:0] key_prev(logic [127:0] k, logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3) ^ {rc, 24'h0};
    return {p0, p1, p2, p3};
  endfunction

  // Byte i sits at bits [127-8i -: 8]; byte index is row + 4*column
  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
        o[127 - 8 * (r + 4 * c) -: 8] = SBOX[v];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_sub_shift(logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = s[127 - 8 * (r + 4 * ((c + 4 - r) % 4)) -: 8];
        o[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[v];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      o[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_mix_cols(logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a   [4];
    logic [7:0]   m9  [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    logic [7:0]   x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = s[127 - 32 * c - 8 * k -: 8];
        x2     = xtime(a[k]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[k]  = x8 ^ a[k];
        m11[k] = x8 ^ x2 ^ a[k];
        m13[k] = x8 ^ x4 ^ a[k];
        m14[k] = x8 ^ x4 ^ x2;
      end
      o[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      o[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      o[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      o[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aes_cbc_ctrl.sv @@
`default_nettype none

module aes_cbc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire logic             mode_i,
  output aes_cbc_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_KEXP  = 2'd1;
  localparam logic [1:0] S_ADDK  = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  logic [1:0] state_q, state_d;
  logic [3:0] rnd_q, rnd_d;
  logic       mode_q, mode_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, last, stall, finish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);

  // Last round waits while the output register is still full
  assign last   = (state_q == S_ROUND) &&
                  (mode_q ? (rnd_q == 4'd0) : (rnd_q == aes_cbc_pkg::LAST_ROUND));
  assign stall  = last && out_valid_q && !out_ready_i;
  assign finish = last && !stall;

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.kexp  = (state_q == S_KEXP);
    cmd_o.addk  = (state_q == S_ADDK);
    cmd_o.round = (state_q == S_ROUND) && !stall;
    cmd_o.dec   = accept ? mode_i : mode_q;
    cmd_o.rnd   = rnd_q;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d  = mode_i;
          rnd_d   = 4'd1;
          state_d = mode_i ? S_KEXP : S_ROUND;
        end
      end
      S_KEXP: begin
        rnd_d = 4'(rnd_q + 4'd1);
        if (rnd_q == 4'd9) begin
          state_d = S_ADDK;
        end
      end
      S_ADDK: begin
        rnd_d   = 4'd9;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        if (finish) begin
          state_d = S_IDLE;
        end else if (!stall) begin
          rnd_d = mode_q ? 4'(rnd_q - 4'd1) : 4'(rnd_q + 4'd1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= 4'd0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE)) else $error("accepted word did not start");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q) else $error("result not presented");
  a_kexp_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KEXP) |-> mode_q) else $error("key expansion in encrypt");
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (rnd_q <= aes_cbc_pkg::LAST_ROUND))
    else $error("round counter out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/aes_cbc_dp.sv @@
`default_nettype none

module aes_cbc_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire aes_cbc_pkg::cmd_t  cmd_i,
  input  wire logic               first_i,
  input  wire logic [127:0]       data_i,
  output logic                    mode_o,
  output logic [127:0]            result_o
);

  logic         mode_q;
  logic [127:0] key_q, iv_q, chain_q;
  logic [127:0] xor_q, state_q, rkey_q, out_q;
  logic [127:0] ch, enc_t, enc_s, dec_t, dec_s;
  logic         last;

  assign mode_o   = mode_q;
  assign result_o = out_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      key_q  <= '0;
      iv_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aes_cbc_pkg::REG_MODE:   mode_q         <= cfg_data_i[0];
        aes_cbc_pkg::REG_KEY_HI: key_q[127:64]  <= cfg_data_i;
        aes_cbc_pkg::REG_KEY_LO: key_q[63:0]    <= cfg_data_i;
        aes_cbc_pkg::REG_IV_HI:  iv_q[127:64]   <= cfg_data_i;
        aes_cbc_pkg::REG_IV_LO:  iv_q[63:0]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Round logic
  assign ch    = first_i ? iv_q : chain_q;
  assign enc_t = aes_cbc_pkg::sub_shift(state_q);
  assign enc_s = ((cmd_i.rnd == aes_cbc_pkg::LAST_ROUND) ? enc_t
                  : aes_cbc_pkg::mix_cols(enc_t)) ^ rkey_q;
  assign dec_t = aes_cbc_pkg::inv_sub_shift(state_q) ^ rkey_q;
  assign dec_s = (cmd_i.rnd == 4'd0) ? dec_t : aes_cbc_pkg::inv_mix_cols(dec_t);
  assign last  = cmd_i.dec ? (cmd_i.rnd == 4'd0) : (cmd_i.rnd == aes_cbc_pkg::LAST_ROUND);

  // Chaining value, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (cmd_i.load) begin
      chain_q <= cmd_i.dec ? data_i : ch;
    end else if (cmd_i.round && last && !cmd_i.dec) begin
      chain_q <= enc_s;
    end
  end

  // Cipher state, round key, chaining input and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xor_q   <= ch;
      state_q <= cmd_i.dec ? data_i : (data_i ^ ch ^ key_q);
      rkey_q  <= aes_cbc_pkg::key_next(key_q, aes_cbc_pkg::rcon(4'd1));
    end else if (cmd_i.kexp) begin
      rkey_q  <= aes_cbc_pkg::key_next(rkey_q, aes_cbc_pkg::rcon(4'(cmd_i.rnd + 4'd1)));
    end else if (cmd_i.addk) begin
      state_q <= state_q ^ rkey_q;
      rkey_q  <= aes_cbc_pkg::key_prev(rkey_q, aes_cbc_pkg::rcon(aes_cbc_pkg::LAST_ROUND));
    end else if (cmd_i.round) begin
      if (cmd_i.dec) begin
        state_q <= dec_s;
        rkey_q  <= aes_cbc_pkg::key_prev(rkey_q, aes_cbc_pkg::rcon(cmd_i.rnd));
        if (last) begin
          out_q <= dec_t ^ xor_q;
        end
      end else begin
        state_q <= enc_s;
        rkey_q  <= aes_cbc_pkg::key_next(rkey_q, aes_cbc_pkg::rcon(4'(cmd_i.rnd + 4'd1)));
        if (last) begin
          out_q <= enc_s;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/aes128_cbc_cipher_top.sv @@
// AES-128 cipher in CBC mode, encrypt or decrypt.
// Input channel s_axis_*: one 128-bit block per word; tuser = 1 restarts
// chaining from the IV. Output channel m_axis_*: one result block per word.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mode, 1/2 key high/low, 3/4 IV high/low); write only while idle.
// Encrypt: the first round key is added as the word is taken, then 10
// rounds, one per cycle unless a stalled receiver holds the last round.
// Decrypt: the key schedule runs forward to the last round key, a
// further step adds it, then 10 inverse rounds walk the schedule back;
// the result is valid once the last round has filled the output register.
// A new word is taken only after the previous one has left the rounds,
// because the single round unit is shared and chaining links the blocks.
// A new word is taken as soon as the round unit is free, even while the
// previous result still sits in the output register. If the receiver
// stalls, the final round holds until that register drains.
// Reset clears the config registers, the chaining value and all control;
// no clearing pass is needed.
`default_nettype none

module aes128_cbc_cipher_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // [63:0] data_high, [127:64] data_low
  input  wire logic         s_axis_tuser,   // first_block
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // [63:0] result_high, [127:64] result_low
);

  aes_cbc_pkg::cmd_t cmd;
  logic              mode;
  logic [127:0]      result;

  aes_cbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .mode_i      (mode),
    .cmd_o       (cmd)
  );

  aes_cbc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .first_i    (s_axis_tuser),
    .data_i     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .mode_o     (mode),
    .result_o   (result)
  );

  assign m_axis_tdata = {result[63:0], result[127:64]};

endmodule

`default_nettype wire

@@ bench/aes128_cbc_cipher_top_test.sv @@
`timescale 1ns / 100ps
`default_nettype none

module aes128_cbc_cipher_top_test;
  import aes_cbc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [63:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // [63:0] data_high, [127:64] data_low
  logic         s_axis_tuser;   // first_block
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // [63:0] result_high, [127:64] result_low

  aes128_cbc_cipher_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: registers, chaining value, S-boxes
  logic         dec_mode;
  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
  logic [127:0] chain_val;
  logic [7:0]   sbox_f [256];
  logic [7:0]   sbox_r [256];
  logic [127:0] expected_blocks [$];
  int           err_count;
  int           quiet_cycles;
  bit           idling_on;
  int           rx_stall;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // Build the S-boxes from the field inverse and the affine map
  function automatic void build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_f[x] = s;
      sbox_r[s] = x[7:0];
    end
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] layer_sub_shift(logic [127:0] s, bit inv);
    logic [127:0] o;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[127 - 8 * (r + 4 * c) -: 8] = inv ? sbox_r[byte_at(s, r + 4 * src)]
                                            : sbox_f[byte_at(s, r + 4 * src)];
      end
    return o;
  endfunction

  function automatic logic [127:0] layer_mix(logic [127:0] s, bit inv);
    logic [127:0] o;
    logic [7:0]   m [4];
    logic [7:0]   v;
    if (inv)
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gmul(byte_at(s, 4 * c + k), m[(k + 4 - r) % 4]);
        o[127 - 8 * (4 * c + r) -: 8] = v;
      end
    return o;
  endfunction

  // One CBC step: returns {result_high, result_low}, updates the chaining value
  function automatic logic [127:0] cbc_predict(logic first, logic [127:0] blk);
    logic [31:0]  w [44];
    logic [127:0] rk [11];
    logic [127:0] s;
    logic [31:0]  t;
    logic [7:0]   rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = {sbox_f[t[23:16]], sbox_f[t[15:8]], sbox_f[t[7:0]], sbox_f[t[31:24]]}
            ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i - 4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    if (first) chain_val = {iv_hi, iv_lo};
    if (dec_mode) begin
      s = blk ^ rk[10];
      for (int r = 9; r >= 0; r--) begin
        s = layer_sub_shift(s, 1'b1) ^ rk[r];
        if (r != 0) s = layer_mix(s, 1'b1);
      end
      s ^= chain_val;
      chain_val = blk;
    end else begin
      s = blk ^ chain_val ^ rk[0];
      for (int r = 1; r <= 10; r++) begin
        s = layer_sub_shift(s, 1'b0);
        if (r != 10) s = layer_mix(s, 1'b0);
        s ^= rk[r];
      end
      chain_val = s;
    end
    return s;
  endfunction

  // Register write; block must be idle
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MODE:   dec_mode = val[0];
      REG_KEY_HI: key_hi = val;
      REG_KEY_LO: key_lo = val;
      REG_IV_HI:  iv_hi = val;
      REG_IV_LO:  iv_lo = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic m, logic [63:0] kh, kl, ih, il);
    write_reg(REG_MODE, {63'h0, m});
    write_reg(REG_KEY_HI, kh);
    write_reg(REG_KEY_LO, kl);
    write_reg(REG_IV_HI, ih);
    write_reg(REG_IV_LO, il);
    cfg_we_i <= 1'b0;
  endtask

  // Send one word; called right after a rising edge, returns at the accepting edge
  task automatic send_block(logic first, logic [63:0] hi, logic [63:0] lo);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= {lo, hi};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_blocks.push_back(cbc_predict(first, {hi, lo}));
  endtask

  // Drop valid, wait for every result, then idle for a drain margin
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Chaining starts from zero when no first block follows reset
  task automatic test_reset_chain();
    send_block(1'b0, 64'h0, 64'h0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b0, '1, '1);
    settle();
  endtask

  task automatic test_extremes();
    write_all(1'b0, '1, '1, '1, '1);
    send_block(1'b1, 64'h0, 64'h0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, 64'h0);
    settle();
    write_all(1'b1, '1, '1, '1, '1);
    send_block(1'b1, '1, '1);
    send_block(1'b0, 64'h0, 64'h0);
    settle();
    write_all(1'b1, 64'h0, 64'h0, 64'h0, 64'h0);
    send_block(1'b1, 64'h0, '1);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    settle();
  endtask

  // Mode change mid-message keeps the stored chaining value
  task automatic test_mode_switch();
    write_all(1'b0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
              64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    send_block(1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51);
    settle();
    write_reg(REG_MODE, 64'h1);
    cfg_we_i <= 1'b0;
    send_block(1'b0, 64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef);
    send_block(1'b0, 64'hf69f2445df4f9b17, 64'had2b417be66c3710);
    settle();
  endtask

  // IV is read only on a first block; bad register indexes are ignored
  task automatic test_iv_and_index();
    write_reg(REG_IV_HI, 64'hdeadbeef00c0ffee);
    write_reg(REG_IV_LO, 64'h5555aaaa3333cccc);
    write_reg(3'd5, '1);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    cfg_we_i <= 1'b0;
    send_block(1'b0, 64'h1, 64'h2);
    send_block(1'b1, 64'h1, 64'h2);
    settle();
  endtask

  // Random messages under random settings, extremes mixed in
  task automatic test_random();
    int left, len;
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) idling_on = 1'b0;
      write_all(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(), rand64());
      left = 125;
      while (left > 0) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && left > 0; i++, left--)
          send_block(i == 0 ? 1'b1 : ($urandom_range(0, 15) == 0), rand64(), rand64());
      end
      settle();
    end
  endtask

  // Result checker, output stalls and watchdog
  always @(posedge clk_i) begin
    logic [127:0] exp_blk;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("aes128_cbc_cipher_top_test: done, errors");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (m_axis_tdata[63:0] !== exp_blk[127:64]) begin
            $display("%0t: result_high exp %h got %h", $time, exp_blk[127:64],
                     m_axis_tdata[63:0]);
            err_count++;
          end
          if (m_axis_tdata[127:64] !== exp_blk[63:0]) begin
            $display("%0t: result_low exp %h got %h", $time, exp_blk[63:0],
                     m_axis_tdata[127:64]);
            err_count++;
          end
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MODE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    err_count = 0;
    quiet_cycles = 0;
    rx_stall = 0;
    idling_on = 1'b1;
    dec_mode = 1'b0;
    key_hi = '0;
    key_lo = '0;
    iv_hi = '0;
    iv_lo = '0;
    chain_val = '0;
    build_sboxes();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_chain();
    test_extremes();
    test_mode_switch();
    test_iv_and_index();
    test_random();

    if (err_count == 0)
      $display("aes128_cbc_cipher_top_test: done, clean");
    else
      $display("aes128_cbc_cipher_top_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/aes_cbc_pkg.sv
hw/rtl/aes_cbc_ctrl.sv
hw/rtl/aes_cbc_dp.sv
hw/rtl/aes128_cbc_cipher_top.sv
bench/aes128_cbc_cipher_top_test.sv
